// ----- hw/rtl/sfd_pkg.sv -----
// Package for the sensor frame deframer: parser phases, verdict codes,
// frame constants and the byte-wise CRC-16 (poly 0x1021) update.
// No dependencies.
package sfd_pkg;

  typedef enum logic [6:0] {
    PH_HUNT   = 7'b0000001,
    PH_KIND   = 7'b0000010,
    PH_LEN_LO = 7'b0000100,
    PH_LEN_HI = 7'b0001000,
    PH_CRC_LO = 7'b0010000,
    PH_CRC_HI = 7'b0100000,
    PH_BODY   = 7'b1000000
  } phase_e;

  typedef enum logic [1:0] {
    VERDICT_PENDING  = 2'd0,
    VERDICT_CRC_GOOD = 2'd1,
    VERDICT_CRC_BAD  = 2'd2,
    VERDICT_OVERFLOW = 2'd3
  } verdict_e;

  localparam logic [7:0]  SYNC_BYTE = 8'h5A;
  localparam logic [7:0]  KIND_DATA = 8'hA5;
  localparam logic [7:0]  KIND_PING = 8'hA6;
  localparam logic [7:0]  KIND_SKIP = 8'hA7;
  localparam int unsigned SKIP_LEN  = 8;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] CRC_TOP   = 16'h8000;

  // One byte through the CRC, MSB first; unrolls into an XOR network.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // CRC after the sync and data-type bytes.
  localparam logic [15:0] CRC_AFTER_HDR = crc_feed(crc_feed(16'h0000, SYNC_BYTE), KIND_DATA);

endpackage

// ----- hw/rtl/sfd_rx_if.sv -----
// Byte stream channel into the deframer: valid/ready plus one received byte.
// No dependencies.
interface sfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Payload channel out of the deframer: one payload byte with index and verdict.
interface sfd_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic [7:0] byte_index;
  logic       frame_end;
  logic [1:0] verdict;

  modport source (output valid, output payload_byte, output byte_index,
                  output frame_end, output verdict, input ready);
  modport sink   (input valid, input payload_byte, input byte_index,
                  input frame_end, input verdict, output ready);
endinterface

// ----- hw/rtl/sensor_frame_deframer_crc16_core.sv -----
// Sensor frame deframer top level: sync/type/length/CRC parser with a running
// CRC-16 and a registered payload output. Uses sfd_pkg, sfd_rx_if, sfd_tx_if.
//
//   channel | dir | payload                                        | transfer when
//   rx_i    | in  | rx_byte[7:0]                                   | valid & ready
//   tx_o    | out | payload_byte[7:0] byte_index[7:0] frame_end verdict[1:0] | valid & ready
//
// One byte per cycle while rx_i is ready; the parser state and CRC update in the cycle the
// byte transfers, and a payload byte appears on tx_o the next cycle.
// The output register decouples the sides: rx_i stays ready while tx_o is empty
// or its held byte transfers in the same cycle; a stalled tx_o stops rx_i.
// Reset returns the parser to sync hunting and empties the output register.
module sensor_frame_deframer_crc16_core #(
  parameter int unsigned MAX_PAYLOAD = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  sfd_rx_if.sink   rx_i,
  sfd_tx_if.source tx_o
);

  localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);

  sfd_pkg::phase_e phase_q, phase_d;
  logic            is_data_q, is_data_d;
  logic [15:0]     len_q, len_d;
  logic [15:0]     rcv_crc_q, rcv_crc_d;
  logic [15:0]     run_crc_q, run_crc_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  logic            out_valid_q;
  logic [7:0]      out_byte_q, out_index_q;
  logic            out_end_q;
  sfd_pkg::verdict_e out_verdict_q;

  logic            emit;
  logic            emit_end;
  sfd_pkg::verdict_e emit_verdict;
  logic [CW-1:0]   cnt_inc;
  logic [15:0]     crc_body;
  logic            accept;

  assign rx_i.ready = !out_valid_q || tx_o.ready;
  assign accept     = rx_i.valid && rx_i.ready;
  assign cnt_inc    = cnt_q + CW'(1);
  assign crc_body   = sfd_pkg::crc_feed(run_crc_q, rx_i.rx_byte);

  always_comb begin
    phase_d      = phase_q;
    is_data_d    = is_data_q;
    len_d        = len_q;
    rcv_crc_d    = rcv_crc_q;
    run_crc_d    = run_crc_q;
    cnt_d        = cnt_q;
    emit         = 1'b0;
    emit_end     = 1'b0;
    emit_verdict = sfd_pkg::VERDICT_PENDING;
    unique case (phase_q)
      sfd_pkg::PH_HUNT: begin
        if (rx_i.rx_byte == sfd_pkg::SYNC_BYTE) phase_d = sfd_pkg::PH_KIND;
      end
      sfd_pkg::PH_KIND: begin
        is_data_d = (rx_i.rx_byte == sfd_pkg::KIND_DATA);
        priority if (rx_i.rx_byte == sfd_pkg::KIND_DATA) begin
          run_crc_d = sfd_pkg::CRC_AFTER_HDR;
          phase_d   = sfd_pkg::PH_LEN_LO;
        end else if (rx_i.rx_byte == sfd_pkg::KIND_PING) begin
          phase_d = sfd_pkg::PH_HUNT;
        end else if (rx_i.rx_byte == sfd_pkg::KIND_SKIP) begin
          cnt_d   = '0;
          phase_d = sfd_pkg::PH_BODY;
        end else begin
          // unknown type: keep waiting for a type byte
          phase_d = sfd_pkg::PH_KIND;
        end
      end
      sfd_pkg::PH_LEN_LO: begin
        len_d     = {8'h00, rx_i.rx_byte};
        run_crc_d = crc_body;
        phase_d   = sfd_pkg::PH_LEN_HI;
      end
      sfd_pkg::PH_LEN_HI: begin
        len_d     = {rx_i.rx_byte, len_q[7:0]};
        run_crc_d = crc_body;
        phase_d   = sfd_pkg::PH_CRC_LO;
      end
      sfd_pkg::PH_CRC_LO: begin
        rcv_crc_d = {8'h00, rx_i.rx_byte};
        phase_d   = sfd_pkg::PH_CRC_HI;
      end
      sfd_pkg::PH_CRC_HI: begin
        rcv_crc_d = {rx_i.rx_byte, rcv_crc_q[7:0]};
        cnt_d     = '0;
        phase_d   = sfd_pkg::PH_BODY;
      end
      sfd_pkg::PH_BODY: begin
        cnt_d = cnt_inc;
        if (!is_data_q) begin
          if (cnt_inc >= CW'(sfd_pkg::SKIP_LEN) || cnt_inc >= CW'(MAX_PAYLOAD)) begin
            phase_d = sfd_pkg::PH_HUNT;
          end
        end else begin
          run_crc_d = crc_body;
          emit      = 1'b1;
          // overflow check takes precedence over the length check
          priority if (cnt_inc >= CW'(MAX_PAYLOAD)) begin
            emit_end     = 1'b1;
            emit_verdict = sfd_pkg::VERDICT_OVERFLOW;
            phase_d      = sfd_pkg::PH_HUNT;
          end else if (17'(cnt_inc) >= {1'b0, len_q}) begin
            emit_end     = 1'b1;
            emit_verdict = (crc_body == rcv_crc_q) ? sfd_pkg::VERDICT_CRC_GOOD
                                                   : sfd_pkg::VERDICT_CRC_BAD;
            phase_d      = sfd_pkg::PH_HUNT;
          end else begin
            emit_end = 1'b0;
          end
        end
      end
      default: begin
        phase_d = sfd_pkg::PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= sfd_pkg::PH_HUNT;
      is_data_q   <= 1'b0;
      len_q       <= '0;
      rcv_crc_q   <= '0;
      run_crc_q   <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q     <= phase_d;
        is_data_q   <= is_data_d;
        len_q       <= len_d;
        rcv_crc_q   <= rcv_crc_d;
        run_crc_q   <= run_crc_d;
        cnt_q       <= cnt_d;
        out_valid_q <= emit;
      end else if (tx_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload of the output register; load only when a byte is emitted.
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      out_byte_q    <= rx_i.rx_byte;
      out_index_q   <= 8'(cnt_q);
      out_end_q     <= emit_end;
      out_verdict_q <= emit_verdict;
    end
  end

  assign tx_o.valid        = out_valid_q;
  assign tx_o.payload_byte = out_byte_q;
  assign tx_o.byte_index   = out_index_q;
  assign tx_o.frame_end    = out_end_q;
  assign tx_o.verdict      = out_verdict_q;

endmodule
